// ===== hw/rtl/blt_pkg.sv =====
// ---------------------------------------------------------------------------
// blt_pkg
// Shared types and constants for the battery level tracker.
// ---------------------------------------------------------------------------
package blt_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int THRESH_BITS   = 12;
    localparam int WIN_BITS      = 8;
    localparam int CNT_BITS      = 4;
    localparam int LEVEL_BITS    = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    // comparison width for sample against thresholds
    localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    // window bounds must hold both a re-armed value and the reset value
    localparam int BOUND_RESET = 1000;
    localparam int UB_BITS = (SAMPLE_BITS + 1 > 10) ? SAMPLE_BITS + 1 : 10;
    localparam int LB_BITS = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;

    localparam logic [THRESH_BITS-1:0] THRESH_OVER_RST = THRESH_BITS'(702);
    localparam logic [THRESH_BITS-1:0] THRESH_FULL_RST = THRESH_BITS'(1293);
    localparam logic [THRESH_BITS-1:0] THRESH_TWO_RST  = THRESH_BITS'(1404);
    localparam logic [THRESH_BITS-1:0] THRESH_ONE_RST  = THRESH_BITS'(1586);
    localparam logic [THRESH_BITS-1:0] THRESH_ZERO_RST = THRESH_BITS'(1638);
    localparam logic [WIN_BITS-1:0]    WIN_HALF_RST    = WIN_BITS'(32);
    localparam logic [CNT_BITS-1:0]    CONFIRM_RST     = CNT_BITS'(9);

    typedef enum logic [LEVEL_BITS-1:0] {
        LV_EMPTY = 3'd0,
        LV_ZERO  = 3'd1,
        LV_ONE   = 3'd2,
        LV_TWO   = 3'd3,
        LV_FULL  = 3'd4,
        LV_OVER  = 3'd5
    } level_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESH_OVER   = 3'd0,
        REG_THRESH_FULL   = 3'd1,
        REG_THRESH_TWO    = 3'd2,
        REG_THRESH_ONE    = 3'd3,
        REG_THRESH_ZERO   = 3'd4,
        REG_WINDOW_HALF   = 3'd5,
        REG_CONFIRM_LIMIT = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLS_DIRECT = 2'd0,
        CLS_RISE   = 2'd1,
        CLS_FALL   = 2'd2
    } cls_mode_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] over;
        logic [THRESH_BITS-1:0] full;
        logic [THRESH_BITS-1:0] two;
        logic [THRESH_BITS-1:0] one;
        logic [THRESH_BITS-1:0] zero;
    } thresh_t;

endpackage

// ===== hw/rtl/blt_classify.sv =====
// ---------------------------------------------------------------------------
// blt_classify
// Threshold classification of one sample: direct, rising-only or falling-only.
// ---------------------------------------------------------------------------
module blt_classify (
    input  logic [blt_pkg::SAMPLE_BITS-1:0] sample,
    input  blt_pkg::level_t                 cur_level,
    input  blt_pkg::cls_mode_t              mode,
    input  blt_pkg::thresh_t                thresh,
    output blt_pkg::level_t                 new_level
);

    logic [blt_pkg::CMP_BITS-1:0] s_ext;
    logic le_over;
    logic le_full;
    logic le_two;
    logic le_one;
    logic le_zero;

    assign s_ext   = blt_pkg::CMP_BITS'(sample);
    assign le_over = s_ext <= blt_pkg::CMP_BITS'(thresh.over);
    assign le_full = s_ext <= blt_pkg::CMP_BITS'(thresh.full);
    assign le_two  = s_ext <= blt_pkg::CMP_BITS'(thresh.two);
    assign le_one  = s_ext <= blt_pkg::CMP_BITS'(thresh.one);
    assign le_zero = s_ext <= blt_pkg::CMP_BITS'(thresh.zero);

    // first matching threshold wins, in fixed order
    always_comb
    begin
        new_level = cur_level;
        unique case (mode)
            blt_pkg::CLS_DIRECT:
            begin
                if (le_over)      new_level = blt_pkg::LV_OVER;
                else if (le_full) new_level = blt_pkg::LV_FULL;
                else if (le_two)  new_level = blt_pkg::LV_TWO;
                else if (le_one)  new_level = blt_pkg::LV_ONE;
                else if (le_zero) new_level = blt_pkg::LV_ZERO;
                else              new_level = blt_pkg::LV_EMPTY;
            end
            blt_pkg::CLS_RISE:
            begin
                if (le_over)
                    new_level = blt_pkg::LV_OVER;
                else if (le_full)
                    new_level = blt_pkg::LV_FULL;
                else if (le_two && cur_level <= blt_pkg::LV_TWO)
                    new_level = blt_pkg::LV_TWO;
                else if (le_one && cur_level <= blt_pkg::LV_ONE)
                    new_level = blt_pkg::LV_ONE;
                else if (le_zero && cur_level <= blt_pkg::LV_ZERO)
                    new_level = blt_pkg::LV_ZERO;
                else
                    new_level = cur_level;
            end
            blt_pkg::CLS_FALL:
            begin
                if (le_over)
                    new_level = blt_pkg::LV_OVER;
                else if (le_full && cur_level >= blt_pkg::LV_FULL)
                    new_level = blt_pkg::LV_FULL;
                else if (le_two && cur_level >= blt_pkg::LV_TWO)
                    new_level = blt_pkg::LV_TWO;
                else if (le_one && cur_level >= blt_pkg::LV_ONE)
                    new_level = blt_pkg::LV_ONE;
                else if (le_zero && cur_level >= blt_pkg::LV_ZERO)
                    new_level = blt_pkg::LV_ZERO;
                else
                    new_level = blt_pkg::LV_EMPTY;
            end
            default: new_level = cur_level;
        endcase
    end

endmodule

// ===== hw/rtl/battery_level_tracker.sv =====
// An accepted sample beat goes to the input register, then through one pass
// of compare and add logic to the level register, which doubles as the
// output register. Throughput: one sample per cycle while out_stall is low.
// Reset: thresholds, window and confirm limit return to defaults, window
// bounds to 1000, confirm count to 0 and the level to full; no clearing pass.
// ---------------------------------------------------------------------------
// battery_level_tracker
// Six-step battery level from ADC samples with a stability window, confirm
// count and charger-directed hysteresis.
// ---------------------------------------------------------------------------
module battery_level_tracker (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [blt_pkg::SAMPLE_BITS-1:0]   sample,
    input  logic                              ready_req,
    input  logic                              charging,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [blt_pkg::LEVEL_BITS-1:0]    level,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [blt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [blt_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    // input stage
    logic                            in_vld_reg;
    logic [blt_pkg::SAMPLE_BITS-1:0] in_sample_reg;
    logic                            in_ready_reg;
    logic                            in_chg_reg;

    // output stage
    logic                            out_vld_reg;

    // configuration
    blt_pkg::thresh_t                thresh_reg;
    logic [blt_pkg::WIN_BITS-1:0]    win_half_reg;
    logic [blt_pkg::CNT_BITS-1:0]    confirm_limit_reg;

    // tracking state
    logic [blt_pkg::UB_BITS-1:0]     upper_bound_reg;
    logic [blt_pkg::UB_BITS-1:0]     upper_bound_next;
    logic [blt_pkg::LB_BITS-1:0]     lower_bound_reg;
    logic [blt_pkg::LB_BITS-1:0]     lower_bound_next;
    logic [blt_pkg::CNT_BITS-1:0]    stable_count_reg;
    logic [blt_pkg::CNT_BITS-1:0]    stable_count_next;
    blt_pkg::level_t                 cur_level_reg;
    blt_pkg::level_t                 cur_level_next;

    logic                            in_accept;
    logic                            advance;
    logic                            leave;
    logic                            count_done;
    blt_pkg::cls_mode_t              mode;
    blt_pkg::level_t                 cls_level;

    logic [blt_pkg::UB_BITS-1:0]     s_ub;
    logic [blt_pkg::LB_BITS-1:0]     s_lb;
    logic [blt_pkg::LB_BITS-1:0]     win_lb;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign level     = cur_level_reg;

    assign s_ub   = blt_pkg::UB_BITS'(in_sample_reg);
    assign s_lb   = blt_pkg::LB_BITS'(in_sample_reg);
    assign win_lb = blt_pkg::LB_BITS'(win_half_reg);

    assign leave      = (s_ub >= upper_bound_reg) ||
                        (blt_pkg::UB_BITS'(lower_bound_reg) >= s_ub);
    assign count_done = stable_count_reg >= confirm_limit_reg;
    assign mode       = !in_ready_reg ? blt_pkg::CLS_DIRECT :
                        (in_chg_reg ? blt_pkg::CLS_RISE : blt_pkg::CLS_FALL);

    blt_classify u_classify (
        .sample    (in_sample_reg),
        .cur_level (cur_level_reg),
        .mode      (mode),
        .thresh    (thresh_reg),
        .new_level (cls_level)
    );

    always_comb
    begin
        upper_bound_next  = upper_bound_reg;
        lower_bound_next  = lower_bound_reg;
        stable_count_next = stable_count_reg;
        cur_level_next    = cur_level_reg;
        if (!in_ready_reg)
        begin
            cur_level_next = cls_level;
        end
        else
        begin
            // window re-arms on every tracked sample, lower edge floors at 0
            upper_bound_next = s_ub + blt_pkg::UB_BITS'(win_half_reg);
            lower_bound_next = (s_lb >= win_lb) ? (s_lb - win_lb) : '0;
            if (leave)
                stable_count_next = '0;
            else if (!count_done)
                stable_count_next = stable_count_reg + blt_pkg::CNT_BITS'(1);
            else
                cur_level_next = cls_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            upper_bound_reg  <= blt_pkg::UB_BITS'(blt_pkg::BOUND_RESET);
            lower_bound_reg  <= blt_pkg::LB_BITS'(blt_pkg::BOUND_RESET);
            stable_count_reg <= '0;
            cur_level_reg    <= blt_pkg::LV_FULL;
        end
        else
        begin
            if (in_accept)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;

            if (advance)
            begin
                upper_bound_reg  <= upper_bound_next;
                lower_bound_reg  <= lower_bound_next;
                stable_count_reg <= stable_count_next;
                cur_level_reg    <= cur_level_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.over   <= blt_pkg::THRESH_OVER_RST;
            thresh_reg.full   <= blt_pkg::THRESH_FULL_RST;
            thresh_reg.two    <= blt_pkg::THRESH_TWO_RST;
            thresh_reg.one    <= blt_pkg::THRESH_ONE_RST;
            thresh_reg.zero   <= blt_pkg::THRESH_ZERO_RST;
            win_half_reg      <= blt_pkg::WIN_HALF_RST;
            confirm_limit_reg <= blt_pkg::CONFIRM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (blt_pkg::cfg_idx_t'(cfg_index))
                blt_pkg::REG_THRESH_OVER:
                    thresh_reg.over <= blt_pkg::THRESH_BITS'(cfg_data);
                blt_pkg::REG_THRESH_FULL:
                    thresh_reg.full <= blt_pkg::THRESH_BITS'(cfg_data);
                blt_pkg::REG_THRESH_TWO:
                    thresh_reg.two <= blt_pkg::THRESH_BITS'(cfg_data);
                blt_pkg::REG_THRESH_ONE:
                    thresh_reg.one <= blt_pkg::THRESH_BITS'(cfg_data);
                blt_pkg::REG_THRESH_ZERO:
                    thresh_reg.zero <= blt_pkg::THRESH_BITS'(cfg_data);
                blt_pkg::REG_WINDOW_HALF:
                    win_half_reg <= cfg_data[blt_pkg::WIN_BITS-1:0];
                blt_pkg::REG_CONFIRM_LIMIT:
                    confirm_limit_reg <= cfg_data[blt_pkg::CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_sample_reg <= sample;
            in_ready_reg  <= ready_req;
            in_chg_reg    <= charging;
        end
    end

`ifndef SYNTH
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_level_reg <= blt_pkg::LV_OVER)
        else $error("level out of range");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        blt_pkg::UB_BITS'(lower_bound_reg) <= upper_bound_reg)
        else $error("window lower bound above upper bound");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_ready_reg && !leave && !count_done)
        |=> stable_count_reg == $past(stable_count_reg) + blt_pkg::CNT_BITS'(1))
        else $error("confirm count did not step");

    a_direct_keeps_window: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_ready_reg)
        |=> $stable(upper_bound_reg) && $stable(lower_bound_reg)
            && $stable(stable_count_reg))
        else $error("direct classification touched window state");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && out_stall) |-> in_stall)
        else $error("input taken while both stages held");
`endif

endmodule
